// ===== design/qrs_pkg.sv =====
`timescale 1ns / 1ps
package qrs_pkg;

   // root_status codes
   localparam logic [1:0] ST_NOT_QUAD = 2'd0;
   localparam logic [1:0] ST_NO_REAL  = 2'd1;
   localparam logic [1:0] ST_DOUBLE   = 2'd2;
   localparam logic [1:0] ST_TWO      = 2'd3;

   // square root: 50-bit radicand, 25 result bits
   localparam int SQ_BITS  = 25;
   localparam int RAD_W    = 2 * SQ_BITS;
   localparam int SREM_W   = SQ_BITS + 2;
   // divider: 32-bit dividend magnitude, 17-bit divisor magnitude
   localparam int DIV_BITS = 32;
   localparam int DVS_W    = 17;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [24:0] nb;     // -b * 256
      logic signed [15:0] a;
   } side_type;

   typedef struct packed {
      side_type            side;
      logic [RAD_W-1:0]    rad;
      logic [SREM_W-1:0]   rem;
      logic [SQ_BITS-1:0]  root;
   } sq_type;

   typedef struct packed {
      logic [1:0]          status;
      logic                neg_p;
      logic                neg_m;
      logic [DVS_W-1:0]    dvs;
      logic [DIV_BITS-1:0] qp;
      logic [DVS_W-1:0]    rp;
      logic [DIV_BITS-1:0] qm;
      logic [DVS_W-1:0]    rm;
   } dv_type;

endpackage

// ===== design/quadratic_root_solver.sv =====
`timescale 1ns / 1ps
// Real roots of a*x^2 + b*x + c = 0 for signed Q8.8 coefficients, in Q16.16.
// Fully pipelined: one coefficient set is accepted every cycle while the
// result side does not stall. The stages are the product registers, the
// square root entry, the bit-serial square root (25 stages, one root bit
// each), the divider entry, the two parallel restoring dividers (32 stages,
// one quotient bit each) and the output registers. A stall on the result side
// holds the whole pipeline; nothing is lost or repeated.
module quadratic_root_solver (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_coef_a,
   input  logic signed [15:0]  req_coef_b,
   input  logic signed [15:0]  req_coef_c,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_root_status,
   output logic signed [31:0]  rsp_root_plus,
   output logic signed [31:0]  rsp_root_minus,
   output logic                rsp_saturated
);
   import qrs_pkg::*;

   localparam int NSTG = 1 + (SQ_BITS + 1) + (DIV_BITS + 1) + 1;

   logic                advance;
   logic [NSTG-1:0]     vld_ff;

   // stage 1 registers
   logic signed [31:0]  bb_ff;
   logic signed [31:0]  ac_ff;
   side_type            s1_ff;

   sq_type              sq_ff [0:SQ_BITS];
   sq_type              sq_in [0:SQ_BITS];
   dv_type              dv_ff [0:DIV_BITS];
   dv_type              dv_in [0:DIV_BITS];

   logic [1:0]          st_ff;
   logic signed [31:0]  rp_ff;
   logic signed [31:0]  rm_ff;
   logic                sat_ff;

   logic [1:0]          st_in;
   logic signed [31:0]  rp_in;
   logic signed [31:0]  rm_in;
   logic                sat_in;

   logic signed [34:0]  disc;
   logic signed [26:0]  np;
   logic signed [26:0]  nm;
   logic [26:0]         np_mag;
   logic [26:0]         nm_mag;

   function automatic sq_type sq_step(input sq_type s);
      sq_type               r;
      logic [SREM_W-1:0]    t;
      logic [SREM_W-1:0]    trial;
      r = s;
      t = {s.rem[SREM_W-3:0], s.rad[RAD_W-1 -: 2]};
      trial = {s.root, 2'b01};
      r.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (t >= trial) begin
         r.rem  = t - trial;
         r.root = {s.root[SQ_BITS-2:0], 1'b1};
      end else begin
         r.rem  = t;
         r.root = {s.root[SQ_BITS-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic dv_type dv_step(input dv_type s);
      dv_type           r;
      logic [DVS_W-1:0] tp;
      logic [DVS_W-1:0] tm;
      logic             gp;
      logic             gm;
      r = s;
      tp = {s.rp[DVS_W-2:0], s.qp[DIV_BITS-1]};
      tm = {s.rm[DVS_W-2:0], s.qm[DIV_BITS-1]};
      gp = (tp >= s.dvs);
      gm = (tm >= s.dvs);
      r.rp = gp ? tp - s.dvs : tp;
      r.rm = gm ? tm - s.dvs : tm;
      r.qp = {s.qp[DIV_BITS-2:0], gp};
      r.qm = {s.qm[DIV_BITS-2:0], gm};
      return r;
   endfunction

   // apply sign and clip one quotient magnitude
   function automatic logic [32:0] finish(input logic neg, input logic [31:0] q);
      logic [32:0] r;
      if (!neg) begin
         r = q[31] ? {1'b1, 32'h7FFF_FFFF} : {1'b0, q};
      end else if (q > 32'h8000_0000) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, 32'd0 - q};
      end
      return r;
   endfunction

   assign advance   = !vld_ff[NSTG-1] || rsp_ready;
   assign req_ready = advance;

   // discriminant and square root entry
   always_comb begin
      disc = 35'(bb_ff) - (35'(ac_ff) <<< 2);
      sq_in[0].side.a  = s1_ff.a;
      sq_in[0].side.nb = s1_ff.nb;
      sq_in[0].rem     = '0;
      sq_in[0].root    = '0;
      if (s1_ff.a == 16'sd0) begin
         sq_in[0].side.status = ST_NOT_QUAD;
         sq_in[0].rad         = '0;
      end else if (disc < 0) begin
         sq_in[0].side.status = ST_NO_REAL;
         sq_in[0].rad         = '0;
      end else if (disc == 0) begin
         sq_in[0].side.status = ST_DOUBLE;
         sq_in[0].rad         = '0;
      end else begin
         sq_in[0].side.status = ST_TWO;
         sq_in[0].rad         = {1'b0, disc[32:0], 16'd0};
      end
      for (int i = 1; i <= SQ_BITS; i++) begin
         sq_in[i] = sq_step(sq_ff[i-1]);
      end
   end

   // numerators and divider entry
   always_comb begin
      np = 27'(sq_ff[SQ_BITS].side.nb) + $signed({2'b00, sq_ff[SQ_BITS].root});
      nm = 27'(sq_ff[SQ_BITS].side.nb) - $signed({2'b00, sq_ff[SQ_BITS].root});
      np_mag = np[26] ? 27'd0 - np : np;
      nm_mag = nm[26] ? 27'd0 - nm : nm;
      dv_in[0].status = sq_ff[SQ_BITS].side.status;
      dv_in[0].neg_p  = np[26] ^ sq_ff[SQ_BITS].side.a[15];
      dv_in[0].neg_m  = nm[26] ^ sq_ff[SQ_BITS].side.a[15];
      dv_in[0].dvs    = sq_ff[SQ_BITS].side.a[15] ?
                        17'd0 - 17'(sq_ff[SQ_BITS].side.a) : 17'(sq_ff[SQ_BITS].side.a);
      dv_in[0].qp     = {np_mag[24:0], 7'd0};
      dv_in[0].qm     = {nm_mag[24:0], 7'd0};
      dv_in[0].rp     = '0;
      dv_in[0].rm     = '0;
      for (int i = 1; i <= DIV_BITS; i++) begin
         dv_in[i] = dv_step(dv_ff[i-1]);
      end
   end

   // sign, clip and zero the roots
   always_comb begin
      logic [32:0] fp;
      logic [32:0] fm;
      fp = finish(dv_ff[DIV_BITS].neg_p, dv_ff[DIV_BITS].qp);
      fm = finish(dv_ff[DIV_BITS].neg_m, dv_ff[DIV_BITS].qm);
      st_in = dv_ff[DIV_BITS].status;
      if (st_in == ST_DOUBLE || st_in == ST_TWO) begin
         rp_in  = fp[31:0];
         rm_in  = fm[31:0];
         sat_in = fp[32] | fm[32];
      end else begin
         rp_in  = '0;
         rm_in  = '0;
         sat_in = 1'b0;
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_valid};
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         bb_ff    <= req_coef_b * req_coef_b;
         ac_ff    <= req_coef_a * req_coef_c;
         s1_ff.a  <= req_coef_a;
         s1_ff.nb <= -(25'(req_coef_b) <<< 8);
         s1_ff.status <= ST_NOT_QUAD;
         for (int i = 0; i <= SQ_BITS; i++) begin
            sq_ff[i] <= sq_in[i];
         end
         for (int i = 0; i <= DIV_BITS; i++) begin
            dv_ff[i] <= dv_in[i];
         end
         st_ff  <= st_in;
         rp_ff  <= rp_in;
         rm_ff  <= rm_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid       = vld_ff[NSTG-1];
   assign rsp_root_status = st_ff;
   assign rsp_root_plus   = rp_ff;
   assign rsp_root_minus  = rm_ff;
   assign rsp_saturated   = sat_ff;

endmodule

// ===== design/qrs_checker.sv =====
`timescale 1ns / 1ps
module qrs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_root_status,
   input logic signed [31:0] rsp_root_plus,
   input logic signed [31:0] rsp_root_minus,
   input logic               rsp_saturated
);
   import qrs_pkg::*;

   // held item's status and plus root stay put while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_root_plus)
         && $stable(rsp_root_status))
      else $error("result item changed while stalled");

   // input side stalls only when the result is held
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

   // no roots means zero fields
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_status == ST_NOT_QUAD || rsp_root_status == ST_NO_REAL)
      |-> rsp_root_plus == 0 && rsp_root_minus == 0 && !rsp_saturated)
      else $error("nonzero roots without real roots");

   // double root gives equal roots
   a_double: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_status == ST_DOUBLE |-> rsp_root_plus == rsp_root_minus)
      else $error("double root differs");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready), .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready), .rsp_root_status(rsp_root_status),
   .rsp_root_plus(rsp_root_plus), .rsp_root_minus(rsp_root_minus),
   .rsp_saturated(rsp_saturated)
);
